// ----- sv/ufp_pkg.sv -----
// Shared types, character codes and hex helpers for the form body decoder.
package ufp_pkg;

   localparam logic [1:0] MODE_SKIP  = 2'd0;
   localparam logic [1:0] MODE_NAME  = 2'd1;
   localparam logic [1:0] MODE_VALUE = 2'd2;

   localparam logic [1:0] ESC_NONE   = 2'd0;
   localparam logic [1:0] ESC_FIRST  = 2'd1;
   localparam logic [1:0] ESC_SECOND = 2'd2;

   localparam logic [1:0] KIND_NAME_BYTE  = 2'd0;
   localparam logic [1:0] KIND_VALUE_BYTE = 2'd1;
   localparam logic [1:0] KIND_NAME_END   = 2'd2;
   localparam logic [1:0] KIND_PAIR_END   = 2'd3;

   localparam logic [7:0] CHAR_AT      = 8'h40;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_CR      = 8'h0D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] HIGH_HALF    = 8'h80;
   localparam logic [7:0] HEX_CASE_MASK  = 8'hDF;
   localparam logic [7:0] HEX_ALPHA_BIAS = 8'd55;

   // Result queue depth and its pointer and level widths.
   localparam int RSP_DEPTH = 4;
   localparam int PTR_W     = $clog2(RSP_DEPTH);
   localparam int LEVEL_W   = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic       has_value;
      logic       bad_escape;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } dec_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

   // Lenient nibble: bytes up to '@' and high bytes subtract '0', others fold case first.
   function automatic logic [7:0] nibble_term(input logic [7:0] c);
      if ((c <= CHAR_AT) || (c >= HIGH_HALF)) begin
         return c - CHAR_ZERO;
      end
      return (c & HEX_CASE_MASK) - HEX_ALPHA_BIAS;
   endfunction

   function automatic logic [7:0] hex_decode(input logic [7:0] hi, input logic [7:0] lo);
      logic [7:0] t_hi;
      logic [7:0] t_lo;
      t_hi = nibble_term(hi);
      t_lo = nibble_term(lo);
      return {t_hi[3:0], 4'b0000} + t_lo;
   endfunction

endpackage

// ----- sv/ufp_if.sv -----
// Handshake interfaces for the raw byte channel and the decoded result channel.
interface ufp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_body;
   modport source (output valid, output data_byte, output end_of_body, input ready);
   modport sink (input valid, input data_byte, input end_of_body, output ready);
endinterface

interface ufp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       has_value;
   logic       bad_escape;
   logic       run_last;
   modport source (output valid, output kind, output out_byte, output has_value,
                   output bad_escape, output run_last, input ready);
   modport sink (input valid, input kind, input out_byte, input has_value,
                 input bad_escape, input run_last, output ready);
endinterface

// ----- sv/urlencoded_form_parser.sv -----
// Top level of the form body decoder: input register, decode, result queue.
//
//   port   dir   carries per item
//   req    in    data_byte, end_of_body: one raw body byte
//   rsp    out   kind, out_byte, has_value, bad_escape, run_last: one result
//
// One byte is taken per cycle while the input register does not stall; its results
// pass the input register and then the result queue. A byte that yields two results
// (a pair closed by the end of the body) pushes both at once; results leave at one per cycle at most.
// The input register stalls while the four-entry result queue has fewer than
// two free entries; req.ready depends only on registers.
// Synchronous reset clears the parser state, the input register and the queue.
module urlencoded_form_parser (
   input  logic         clock,
   input  logic         reset,
   ufp_req_if.sink      req,
   ufp_rsp_if.source    rsp
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eob_ff;

   logic                          room;
   logic                          step;
   logic                          req_fire;
   logic                          pop;
   logic [ufp_pkg::LEVEL_W-1:0]   level;
   ufp_pkg::dec_type              dec;
   ufp_pkg::rsp_type              head;
   logic [1:0]                    push_count;

   assign room       = (level <= ufp_pkg::LEVEL_W'(ufp_pkg::RSP_DEPTH - 2));
   assign step       = in_valid_ff && room;
   assign req.ready  = !in_valid_ff || room;
   assign req_fire   = req.valid && req.ready;
   assign in_valid_in = req_fire || (in_valid_ff && !step);
   assign push_count = step ? dec.count : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req.data_byte;
         in_eob_ff  <= req.end_of_body;
      end
   end

   ufp_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (in_byte_ff),
      .in_eob  (in_eob_ff),
      .dec     (dec)
   );

   ufp_rsp_fifo u_rsp_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_count  (push_count),
      .push_first  (dec.first),
      .push_second (dec.second),
      .pop         (pop),
      .head        (head),
      .level       (level)
   );

   assign pop            = rsp.valid && rsp.ready;
   assign rsp.valid      = (level != '0);
   assign rsp.kind       = head.kind;
   assign rsp.out_byte   = head.out_byte;
   assign rsp.has_value  = head.has_value;
   assign rsp.bad_escape = head.bad_escape;
   assign rsp.run_last   = head.run_last;

   // The queue never holds more results than it has entries.
   assert property (@(posedge clock) disable iff (reset)
      level <= ufp_pkg::LEVEL_W'(ufp_pkg::RSP_DEPTH))
      else $error("result queue overflow");

   // Two results from one byte only happen on the last byte of a body.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && dec.count == 2'd2) |-> in_eob_ff)
      else $error("two results without end of body");

   // The second of two results is always the closing end-of-pair marker; the first is never run_last.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && dec.count == 2'd2) |->
         (dec.second.kind == ufp_pkg::KIND_PAIR_END && !dec.first.run_last))
      else $error("bad ordering of two results");

   // A byte is never taken while the previous one waits for queue room.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !room) |=> (in_byte_ff == $past(in_byte_ff)))
      else $error("stalled input register overwritten");

endmodule

// ----- sv/ufp_decode.sv -----
// Parser state and the per-byte decode into at most two results.
module ufp_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       in_byte,
   input  logic             in_eob,
   output ufp_pkg::dec_type dec
);

   logic [1:0] parse_mode_ff;
   logic [1:0] parse_mode_in;
   logic [1:0] escape_phase_ff;
   logic [1:0] escape_phase_in;
   logic [7:0] escape_high_ff;
   logic [7:0] escape_high_in;

   logic [1:0]       mode_cur;
   logic             emit_v;
   ufp_pkg::rsp_type emit_r;
   logic             close_v;
   ufp_pkg::rsp_type close_r;

   always_comb begin
      mode_cur = ((parse_mode_ff == ufp_pkg::MODE_NAME) ||
                  (parse_mode_ff == ufp_pkg::MODE_VALUE)) ? parse_mode_ff : ufp_pkg::MODE_SKIP;
      parse_mode_in   = mode_cur;
      escape_phase_in = escape_phase_ff;
      escape_high_in  = escape_high_ff;
      emit_v = 1'b0;
      emit_r = '0;

      case (escape_phase_ff)
         ufp_pkg::ESC_FIRST: begin
            escape_high_in  = in_byte;
            escape_phase_in = ufp_pkg::ESC_SECOND;
         end
         ufp_pkg::ESC_SECOND: begin
            emit_v          = 1'b1;
            emit_r.kind     = (mode_cur == ufp_pkg::MODE_VALUE) ?
                              ufp_pkg::KIND_VALUE_BYTE : ufp_pkg::KIND_NAME_BYTE;
            emit_r.out_byte = ufp_pkg::hex_decode(escape_high_ff, in_byte);
            escape_phase_in = ufp_pkg::ESC_NONE;
            escape_high_in  = 8'h00;
         end
         default: begin
            if ((mode_cur == ufp_pkg::MODE_SKIP) && !ufp_pkg::is_space(in_byte) &&
                (in_byte != ufp_pkg::CHAR_AMP)) begin
               parse_mode_in = ufp_pkg::MODE_NAME;
            end
            case (parse_mode_in)
               ufp_pkg::MODE_NAME: begin
                  if (in_byte == ufp_pkg::CHAR_AMP) begin
                     emit_v        = 1'b1;
                     emit_r.kind   = ufp_pkg::KIND_PAIR_END;
                     parse_mode_in = ufp_pkg::MODE_SKIP;
                  end else if (in_byte == ufp_pkg::CHAR_EQUAL) begin
                     emit_v        = 1'b1;
                     emit_r.kind   = ufp_pkg::KIND_NAME_END;
                     parse_mode_in = ufp_pkg::MODE_VALUE;
                  end else if (in_byte == ufp_pkg::CHAR_PERCENT) begin
                     escape_phase_in = ufp_pkg::ESC_FIRST;
                  end else begin
                     emit_v          = 1'b1;
                     emit_r.kind     = ufp_pkg::KIND_NAME_BYTE;
                     emit_r.out_byte = (in_byte == ufp_pkg::CHAR_PLUS) ?
                                       ufp_pkg::CHAR_SPACE : in_byte;
                  end
               end
               ufp_pkg::MODE_VALUE: begin
                  if (in_byte == ufp_pkg::CHAR_AMP) begin
                     emit_v           = 1'b1;
                     emit_r.kind      = ufp_pkg::KIND_PAIR_END;
                     emit_r.has_value = 1'b1;
                     parse_mode_in    = ufp_pkg::MODE_SKIP;
                  end else if (in_byte == ufp_pkg::CHAR_PERCENT) begin
                     escape_phase_in = ufp_pkg::ESC_FIRST;
                  end else begin
                     emit_v          = 1'b1;
                     emit_r.kind     = ufp_pkg::KIND_VALUE_BYTE;
                     emit_r.out_byte = (in_byte == ufp_pkg::CHAR_PLUS) ?
                                       ufp_pkg::CHAR_SPACE : in_byte;
                  end
               end
               default: begin
               end
            endcase
         end
      endcase

      // The last byte of the body closes an open pair; a pending escape is dropped.
      close_v            = in_eob && (parse_mode_in != ufp_pkg::MODE_SKIP);
      close_r            = '0;
      close_r.kind       = ufp_pkg::KIND_PAIR_END;
      close_r.has_value  = (parse_mode_in == ufp_pkg::MODE_VALUE);
      close_r.bad_escape = (escape_phase_in != ufp_pkg::ESC_NONE);
      close_r.run_last   = 1'b1;
      emit_r.run_last    = !close_v;

      if (in_eob) begin
         parse_mode_in   = ufp_pkg::MODE_SKIP;
         escape_phase_in = ufp_pkg::ESC_NONE;
         escape_high_in  = 8'h00;
      end

      dec.count  = {1'b0, emit_v} + {1'b0, close_v};
      dec.first  = emit_v ? emit_r : close_r;
      dec.second = close_r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parse_mode_ff   <= ufp_pkg::MODE_SKIP;
         escape_phase_ff <= ufp_pkg::ESC_NONE;
         escape_high_ff  <= 8'h00;
      end else if (step) begin
         parse_mode_ff   <= parse_mode_in;
         escape_phase_ff <= escape_phase_in;
         escape_high_ff  <= escape_high_in;
      end
   end

endmodule

// ----- sv/ufp_rsp_fifo.sv -----
// Small result queue that takes up to two results a cycle and hands out one.
module ufp_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    push_count,
   input  ufp_pkg::rsp_type              push_first,
   input  ufp_pkg::rsp_type              push_second,
   input  logic                          pop,
   output ufp_pkg::rsp_type              head,
   output logic [ufp_pkg::LEVEL_W-1:0]   level
);

   ufp_pkg::rsp_type                entries_ff [ufp_pkg::RSP_DEPTH];
   logic [ufp_pkg::PTR_W-1:0]       wr_ptr_ff;
   logic [ufp_pkg::PTR_W-1:0]       wr_ptr_in;
   logic [ufp_pkg::PTR_W-1:0]       wr_next;
   logic [ufp_pkg::PTR_W-1:0]       rd_ptr_ff;
   logic [ufp_pkg::PTR_W-1:0]       rd_ptr_in;
   logic [ufp_pkg::LEVEL_W-1:0]     level_ff;
   logic [ufp_pkg::LEVEL_W-1:0]     level_in;

   always_comb begin
      wr_next   = wr_ptr_ff + ufp_pkg::PTR_W'(1);
      wr_ptr_in = wr_ptr_ff + ufp_pkg::PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + ufp_pkg::PTR_W'(pop);
      level_in  = level_ff + ufp_pkg::LEVEL_W'(push_count) - ufp_pkg::LEVEL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entries_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         entries_ff[wr_next] <= push_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   assign head  = entries_ff[rd_ptr_ff];
   assign level = level_ff;

endmodule
